@@ hdl/sjis_fullwidth_digit_converter_defines.svh @@
// Assertion macros used by the converter's top-level RTL file.
// Depends on nothing; include with the bare file name.
`ifndef SJIS_FULLWIDTH_DIGIT_CONVERTER_DEFINES_SVH
`define SJIS_FULLWIDTH_DIGIT_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SFDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sfdc_pkg.sv @@
// Shared types and constants for the Shift-JIS fullwidth digit converter.
// No dependencies; imported by every module of the block.
package sfdc_pkg;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } t_out_item;

    // One unit of work for the back end: one or two bytes to emit.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
        logic       str_end;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic sec_pending;
    } t_back_status;

endpackage

@@ hdl/sjis_fullwidth_digit_converter.sv @@
// Shift-JIS fullwidth/halfwidth digit converter, top level.
// Depends on sfdc_pkg, sfdc_front, sfdc_queue, sfdc_back and the defines header.
//
// Usage: input items (one byte plus an end-of-string flag) enter through a
// queue-style port: an item is taken at a clock edge with push high and full
// low. Results leave the same way: while empty is low the oldest output byte
// is on o_out_item, and it is taken at an edge with pop high.
// Each item gives zero, one or two output bytes. run_last marks the last byte
// of an item, string_end the final byte of a string.
// The 1-bit direction register (0: fullwidth to halfwidth, 1: halfwidth to
// fullwidth) is written through i_cfg_we/i_cfg_wdata. The user must write it
// only while the block is idle; the block does not enforce this. A write
// drops any held lead byte. An item's first byte passes the job queue and then
// the output register, which loads a second byte at the edge taking the first.
// The front end takes one item per cycle while the queue is not full; the back
// end emits one byte per cycle while the receiver takes them, so two-byte items
// cannot keep up. The job queue of QDEPTH entries absorbs short bursts. If the
// receiver stalls, the output byte holds, the queue fills and full rises;
// nothing is lost. Synchronous reset empties the queue and output register,
// clears the held lead byte and sets direction to 0.
`include "sjis_fullwidth_digit_converter_defines.svh"

module sjis_fullwidth_digit_converter #(
    parameter int QDEPTH = sfdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                push,
    output logic                full,
    input  sfdc_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output sfdc_pkg::t_out_item o_out_item
);
    import sfdc_pkg::*;

    t_q_status    q_status;
    t_back_status b_status;
    t_job         f_job;
    t_job         q_job;
    logic         f_push;
    logic         q_pop;
    logic         in_fire;
    logic         out_fire;

    assign full     = q_status.full;
    assign in_fire  = push && !full;
    assign out_fire = pop && !empty;

    sfdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_fire),
        .i_in_item   (i_in_item),
        .o_job_push  (f_push),
        .o_job       (f_job)
    );

    sfdc_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_job    (f_job),
        .i_pop    (q_pop),
        .o_job    (q_job),
        .o_status (q_status)
    );

    sfdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_job_empty (q_status.empty),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item),
        .o_status    (b_status)
    );

    // A pending second byte always sits behind a valid output byte.
    `SFDC_ASSERT_NOW(a_sec_behind_valid, i_clk, i_rst_n, b_status.sec_pending, !empty, "second byte pending with empty output")
    // The end of a string is only ever flagged on an item's last byte.
    `SFDC_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, !empty && o_out_item.string_end, o_out_item.run_last, "string_end without run_last")
    // With nothing queued or pending, taking the output byte drains the block.
    `SFDC_ASSERT_NEXT(a_drain, i_clk, i_rst_n, out_fire && q_status.empty && !b_status.sec_pending, empty, "output not empty after draining")

endmodule

@@ hdl/sfdc_front.sv @@
// Front end: accepts input items, tracks a held lead byte and turns each
// item into a job of zero, one or two output bytes. Depends on sfdc_pkg.
module sfdc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_accept,
    input  sfdc_pkg::t_in_item i_in_item,
    output logic             o_job_push,
    output sfdc_pkg::t_job   o_job
);
    import sfdc_pkg::*;

    localparam logic [7:0] LEAD_DIGIT = 8'h82;
    localparam logic [7:0] LEAD_SYM   = 8'h81;
    localparam logic [7:0] TRAIL_D0   = 8'h4f;
    localparam logic [7:0] TRAIL_D9   = 8'h58;
    localparam logic [7:0] TRAIL_MIN  = 8'h7c;
    localparam logic [7:0] TRAIL_PER  = 8'h44;
    localparam logic [7:0] TRAIL_SPC  = 8'h40;
    localparam logic [7:0] ASC_0      = 8'h30;
    localparam logic [7:0] ASC_9      = 8'h39;
    localparam logic [7:0] ASC_MIN    = 8'h2d;
    localparam logic [7:0] ASC_PER    = 8'h2e;
    localparam logic [7:0] ASC_SPC    = 8'h20;
    // Distance between a fullwidth digit trail byte and its ASCII digit.
    localparam logic [7:0] DIGIT_OFS  = 8'h1f;

    logic       r_direction;
    logic       r_pending;
    logic [7:0] r_held;
    logic       n_pending;
    logic [7:0] n_held;
    logic [7:0] b;
    logic       is_lead;

    assign b       = i_in_item.in_byte;
    assign is_lead = (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hef);

    always_comb begin
        n_pending     = r_pending;
        n_held        = r_held;
        o_job_push    = 1'b0;
        o_job.byte0   = b;
        o_job.byte1   = b;
        o_job.two     = 1'b0;
        o_job.str_end = i_in_item.in_end;
        if (i_accept) begin
            if (!r_direction) begin
                if (r_pending) begin
                    n_pending  = 1'b0;
                    o_job_push = 1'b1;
                    if (r_held == LEAD_DIGIT && b >= TRAIL_D0 && b <= TRAIL_D9) begin
                        o_job.byte0 = b - DIGIT_OFS;
                    end else if (r_held == LEAD_SYM && b == TRAIL_MIN) begin
                        o_job.byte0 = ASC_MIN;
                    end else if (r_held == LEAD_SYM && b == TRAIL_PER) begin
                        o_job.byte0 = ASC_PER;
                    end else if (r_held == LEAD_SYM && b == TRAIL_SPC) begin
                        o_job.byte0 = ASC_SPC;
                    end else begin
                        o_job.byte0 = r_held;
                        o_job.two   = 1'b1;
                    end
                end else if (is_lead && !i_in_item.in_end) begin
                    n_pending = 1'b1;
                    n_held    = b;
                end else begin
                    o_job_push = 1'b1;
                end
            end else begin
                o_job_push = 1'b1;
                if (b >= ASC_0 && b <= ASC_9) begin
                    o_job.byte0 = LEAD_DIGIT;
                    o_job.byte1 = b + DIGIT_OFS;
                    o_job.two   = 1'b1;
                end else if (b == ASC_MIN) begin
                    o_job.byte0 = LEAD_SYM;
                    o_job.byte1 = TRAIL_MIN;
                    o_job.two   = 1'b1;
                end else if (b == ASC_PER) begin
                    o_job.byte0 = LEAD_SYM;
                    o_job.byte1 = TRAIL_PER;
                    o_job.two   = 1'b1;
                end else if (b == ASC_SPC) begin
                    o_job.byte0 = LEAD_SYM;
                    o_job.byte1 = TRAIL_SPC;
                    o_job.two   = 1'b1;
                end
            end
        end
        // A direction write drops any held lead byte.
        if (i_cfg_we) begin
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_pending   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_direction <= i_cfg_wdata;
            end
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

@@ hdl/sfdc_queue.sv @@
// Short job queue that decouples the front end from the back end.
// Depends on sfdc_pkg for the job and status types.
module sfdc_queue #(
    parameter int QDEPTH = sfdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfdc_pkg::t_job      i_job,
    input  logic                i_pop,
    output sfdc_pkg::t_job      o_job,
    output sfdc_pkg::t_q_status o_status
);
    import sfdc_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ hdl/sfdc_back.sv @@
// Back end: takes jobs from the queue and emits their bytes one per cycle
// while the receiver takes them, through an output register. Depends on sfdc_pkg.
module sfdc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sfdc_pkg::t_job         i_job,
    input  logic                   i_job_empty,
    output logic                   o_job_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output sfdc_pkg::t_out_item    o_out_item,
    output sfdc_pkg::t_back_status o_status
);
    import sfdc_pkg::*;

    logic       r_valid;
    t_out_item  r_out;
    logic       r_sec;
    logic [7:0] r_byte1;
    logic       r_end;
    logic       load;

    // The output register refills when it is empty or being taken.
    assign load       = !r_valid || (i_pop && r_valid);
    assign o_job_pop  = load && !r_sec && !i_job_empty;
    assign o_empty    = !r_valid;
    assign o_out_item = r_out;
    assign o_status.sec_pending = r_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sec   <= 1'b0;
        end else if (load) begin
            if (r_sec) begin
                r_valid <= 1'b1;
                r_sec   <= 1'b0;
            end else if (!i_job_empty) begin
                r_valid <= 1'b1;
                r_sec   <= i_job.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_sec) begin
                r_out.out_byte   <= r_byte1;
                r_out.run_last   <= 1'b1;
                r_out.string_end <= r_end;
            end else begin
                r_out.out_byte   <= i_job.byte0;
                r_out.run_last   <= !i_job.two;
                r_out.string_end <= i_job.str_end && !i_job.two;
                r_byte1          <= i_job.byte1;
                r_end            <= i_job.str_end;
            end
        end
    end

endmodule

@@ sim/sjis_fullwidth_digit_converter_test.sv @@
// Self-checking testbench for the Shift-JIS fullwidth/halfwidth digit converter.
// Depends on sfdc_pkg and the sjis_fullwidth_digit_converter top level only.
// A class-based scoreboard predicts every output byte, and plain tasks drive the queue ports.
module sjis_fullwidth_digit_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfdc_pkg::*;

    // Values of the direction register.
    localparam logic DIR_NARROW = 1'b0;   // fullwidth to halfwidth
    localparam logic DIR_WIDE   = 1'b1;   // halfwidth to fullwidth

    // Shift-JIS lead and trail bytes of the converted fullwidth characters.
    localparam logic [7:0] LEAD_DIGIT   = 8'h82;
    localparam logic [7:0] LEAD_SYMBOL  = 8'h81;
    localparam logic [7:0] TRAIL_ZERO   = 8'h4F;
    localparam logic [7:0] TRAIL_NINE   = 8'h58;
    localparam logic [7:0] TRAIL_MINUS  = 8'h7C;
    localparam logic [7:0] TRAIL_PERIOD = 8'h44;
    localparam logic [7:0] TRAIL_SPACE  = 8'h40;

    // Their ASCII counterparts.
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] ASCII_MINUS  = 8'h2D;
    localparam logic [7:0] ASCII_PERIOD = 8'h2E;
    localparam logic [7:0] ASCII_SPACE  = 8'h20;

    // Shows at most this many mismatch lines; all of them are still counted.
    localparam int MAX_REPORTS = 40;

    // The scoreboard keeps its own copy of the direction register and the
    // held lead byte. Every accepted item is turned into the output bytes it
    // should cause, and these wait in order until the block delivers them.
    class width_conv_scoreboard;
        t_out_item  expected_bytes[$];
        logic       direction;
        logic [7:0] held_lead;
        logic       lead_pending;
        int         mismatches;
        int         bytes_checked;
        int         items_noted;
        int         direction_writes;

        function new();
            direction        = DIR_NARROW;
            held_lead        = 8'h00;
            lead_pending     = 1'b0;
            mismatches       = 0;
            bytes_checked    = 0;
            items_noted      = 0;
            direction_writes = 0;
        endfunction

        // A direction write drops any held lead byte without sending it.
        function void write_direction(logic value);
            direction    = value;
            held_lead    = 8'h00;
            lead_pending = 1'b0;
            direction_writes++;
        endfunction

        function void note_input(t_in_item item);
            logic [7:0] b;
            logic       fin;
            logic [7:0] outs [2];
            int         n;
            t_out_item  e;
            b   = item.in_byte;
            fin = item.in_end;
            n   = 0;
            items_noted++;
            if (direction == DIR_NARROW) begin
                if (lead_pending) begin
                    // The second byte of a pair decides whether it folds to ASCII.
                    lead_pending = 1'b0;
                    if (held_lead == LEAD_DIGIT && b >= TRAIL_ZERO && b <= TRAIL_NINE) begin
                        outs[0] = ASCII_ZERO + (b - TRAIL_ZERO);
                        n = 1;
                    end else if (held_lead == LEAD_SYMBOL && b == TRAIL_MINUS) begin
                        outs[0] = ASCII_MINUS;
                        n = 1;
                    end else if (held_lead == LEAD_SYMBOL && b == TRAIL_PERIOD) begin
                        outs[0] = ASCII_PERIOD;
                        n = 1;
                    end else if (held_lead == LEAD_SYMBOL && b == TRAIL_SPACE) begin
                        outs[0] = ASCII_SPACE;
                        n = 1;
                    end else begin
                        outs[0] = held_lead;
                        outs[1] = b;
                        n = 2;
                    end
                end else if (((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF))
                             && !fin) begin
                    // A lead byte waits for its partner and gives nothing yet.
                    held_lead    = b;
                    lead_pending = 1'b1;
                end else begin
                    // Single bytes pass, and so does a lead byte that ends a string.
                    outs[0] = b;
                    n = 1;
                end
            end else begin
                if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
                    outs[0] = LEAD_DIGIT;
                    outs[1] = TRAIL_ZERO + (b - ASCII_ZERO);
                    n = 2;
                end else if (b == ASCII_MINUS) begin
                    outs[0] = LEAD_SYMBOL;
                    outs[1] = TRAIL_MINUS;
                    n = 2;
                end else if (b == ASCII_PERIOD) begin
                    outs[0] = LEAD_SYMBOL;
                    outs[1] = TRAIL_PERIOD;
                    n = 2;
                end else if (b == ASCII_SPACE) begin
                    outs[0] = LEAD_SYMBOL;
                    outs[1] = TRAIL_SPACE;
                    n = 2;
                end else begin
                    outs[0] = b;
                    n = 1;
                end
            end
            for (int k = 0; k < n; k++) begin
                e.out_byte   = outs[k];
                e.run_last   = (k == n - 1);
                e.string_end = (k == n - 1) && fin;
                expected_bytes.push_back(e);
            end
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH at %0t: %s is %02h, expected %02h", $time, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_bytes.size() == 0) begin
                report("output byte with nothing expected", got.out_byte, 0);
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (got.out_byte !== want.out_byte)
                report("out_byte", got.out_byte, want.out_byte);
            if (got.run_last !== want.run_last)
                report("run_last", got.run_last, want.run_last);
            if (got.string_end !== want.string_end)
                report("string_end", got.string_end, want.string_end);
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      push        = 1'b0;
    logic      pop         = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      full;
    logic      empty;
    t_out_item o_out_item;

    width_conv_scoreboard sb = new();

    // Once set, neither side idles any more, so the last phase runs at full rate.
    logic calm = 1'b0;

    // Bytes of the string that the generator has just built.
    logic [7:0] text_bytes[$];

    int stall_left = 0;

    sjis_fullwidth_digit_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiving side. The byte on o_out_item is taken at an edge where pop
    // was high and empty low, and it is checked right there. At random times
    // pop drops for a while, unless the run is in its calm part.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
        end else begin
            if (pop && !empty)
                sb.check_result(o_out_item);
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offers one item and waits until an edge takes it. Push is left high on
    // purpose: if the next item follows at once, push never drops, and the
    // caller lowers it only when it idles or drains.
    task send_byte(input logic [7:0] b, input logic fin);
        t_in_item item;
        item.in_byte = b;
        item.in_end  = fin;
        push      <= 1'b1;
        i_in_item <= item;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sb.note_input(item);
    endtask

    // Sender-side gap with push low, now and then.
    task maybe_idle(input bit allowed);
        if (allowed && !calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted byte has come out, then lets the pipeline
    // run empty, since a held lead byte leaves nothing to wait for.
    task drain;
        push <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // The register takes the value at the next edge; only called while idle.
    task write_direction(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_direction(value);
        i_cfg_we <= 1'b0;
    endtask

    // Builds one string of len bytes. Most of it is well-formed text for the
    // chosen direction, with near misses and random noise mixed in. A string
    // may end in the middle of a pair, which leaves a lead byte at its end.
    task build_text(input int len, input logic dir);
        int r;
        int k;
        text_bytes.delete();
        while (text_bytes.size() < len) begin
            r = $urandom_range(0, 9);
            if (dir == DIR_NARROW) begin
                if (r <= 3) begin
                    k = $urandom_range(0, 12);
                    if (k <= 9) begin
                        text_bytes.push_back(LEAD_DIGIT);
                        text_bytes.push_back(TRAIL_ZERO + k[7:0]);
                    end else begin
                        text_bytes.push_back(LEAD_SYMBOL);
                        text_bytes.push_back(k == 10 ? TRAIL_MINUS :
                                             k == 11 ? TRAIL_PERIOD : TRAIL_SPACE);
                    end
                end else if (r <= 5) begin
                    // Convertible lead with any trail, so edges of the ranges get hit.
                    text_bytes.push_back($urandom_range(0, 1) ? LEAD_DIGIT : LEAD_SYMBOL);
                    text_bytes.push_back(8'($urandom_range(0, 255)));
                end else if (r == 6) begin
                    text_bytes.push_back($urandom_range(0, 1)
                                         ? 8'($urandom_range(8'h81, 8'h9F))
                                         : 8'($urandom_range(8'hE0, 8'hEF)));
                    text_bytes.push_back(8'($urandom_range(0, 255)));
                end else if (r <= 8) begin
                    text_bytes.push_back(8'($urandom_range(0, 127)));
                end else begin
                    text_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end else begin
                if (r <= 4) begin
                    k = $urandom_range(0, 12);
                    text_bytes.push_back(k <= 9  ? ASCII_ZERO + k[7:0] :
                                         k == 10 ? ASCII_MINUS :
                                         k == 11 ? ASCII_PERIOD : ASCII_SPACE);
                end else if (r <= 6) begin
                    text_bytes.push_back(8'($urandom_range(0, 127)));
                end else begin
                    text_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        while (text_bytes.size() > len)
            void'(text_bytes.pop_back());
    endtask

    // One random phase: set the direction while idle, then send whole strings
    // until about n_items bytes have gone in.
    task run_phase(input logic dir, input int n_items);
        int  sent;
        int  len;
        bit  gaps;
        drain();
        write_direction(dir);
        sent = 0;
        while (sent < n_items) begin
            // Mostly short strings, sometimes a long one.
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            gaps = ($urandom_range(0, 3) != 0);
            build_text(len, dir);
            for (int i = 0; i < len; i++) begin
                send_byte(text_bytes[i], i == len - 1);
                maybe_idle(gaps);
            end
            sent += len;
        end
    endtask

    initial begin
        // Reset is held at the start and never asserted again.
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, fullwidth to halfwidth: both ends of the digit range,
        // the trail bytes just outside it, the three symbols, a pair with a
        // zero trail byte, a lead byte that ends its string, and plain bytes.
        write_direction(DIR_NARROW);
        send_byte(LEAD_DIGIT, 1'b0);  send_byte(TRAIL_ZERO, 1'b0);
        send_byte(LEAD_DIGIT, 1'b0);  send_byte(TRAIL_NINE, 1'b0);
        send_byte(LEAD_DIGIT, 1'b0);  send_byte(TRAIL_ZERO - 8'd1, 1'b0);
        send_byte(LEAD_DIGIT, 1'b0);  send_byte(TRAIL_NINE + 8'd1, 1'b0);
        send_byte(LEAD_SYMBOL, 1'b0); send_byte(TRAIL_MINUS, 1'b0);
        send_byte(LEAD_SYMBOL, 1'b0); send_byte(TRAIL_PERIOD, 1'b0);
        send_byte(LEAD_SYMBOL, 1'b0); send_byte(TRAIL_SPACE, 1'b0);
        send_byte(8'hE0, 1'b0);       send_byte(8'h00, 1'b0);
        send_byte(8'h9F, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hEF, 1'b0);       send_byte(8'hFF, 1'b1);
        // This lead byte is still held when the direction changes; the write
        // must drop it.
        send_byte(LEAD_DIGIT, 1'b0);
        drain();

        // Directed part, halfwidth to fullwidth.
        write_direction(DIR_WIDE);
        send_byte(ASCII_ZERO, 1'b0);
        send_byte(ASCII_NINE, 1'b0);
        send_byte(ASCII_MINUS, 1'b0);
        send_byte(ASCII_PERIOD, 1'b0);
        send_byte(ASCII_SPACE, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Random part, about 900 items, with both directions written more
        // than once and the same value written twice in a row.
        run_phase(DIR_NARROW, 150);
        run_phase(DIR_WIDE,   150);
        run_phase(DIR_WIDE,   150);
        run_phase(DIR_NARROW, 150);
        run_phase(DIR_WIDE,   150);
        drain();
        calm = 1'b1;
        run_phase(DIR_NARROW, 150);
        drain();

        $display("Sent %0d items over %0d direction settings; %0d output bytes compared.",
                 sb.items_noted, sb.direction_writes, sb.bytes_checked);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Guard against a hung handshake; far above the slowest correct run.
    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
